// ----- sv/m4vt_pkg.sv -----
// Shared types and constants for the 4x4 matrix-vector transform.
// Used by the register file, the dot-product pipeline and the top level.
`timescale 1ns / 1ps
`default_nettype none

package m4vt_pkg;

  localparam int NUM_ROWS = 4;
  localparam int NUM_COLS = 4;
  localparam int VEC_W    = 16;
  localparam int LANE_W   = 16;
  localparam int ROW_W    = NUM_COLS * LANE_W;
  localparam int DATA_W   = NUM_COLS * VEC_W;
  localparam int ADDR_W   = 5;

  typedef logic [ROW_W-1:0]         row_t;
  typedef row_t [NUM_ROWS-1:0]      matrix_t;
  typedef logic [DATA_W-1:0]        vec_t;
  typedef logic [$clog2(NUM_ROWS)-1:0] reg_idx_t;

  // Register indexes; each 64-bit register sits at byte address 8 * index.
  localparam reg_idx_t REG_ROW0 = 2'd0;
  localparam reg_idx_t REG_ROW1 = 2'd1;
  localparam reg_idx_t REG_ROW2 = 2'd2;
  localparam reg_idx_t REG_ROW3 = 2'd3;

  // Reset matrix is the identity with 1.0 in Q8.8.
  localparam row_t ROW0_RESET = 64'h0000_0000_0000_0100;
  localparam row_t ROW1_RESET = 64'h0000_0000_0100_0000;
  localparam row_t ROW2_RESET = 64'h0000_0100_0000_0000;
  localparam row_t ROW3_RESET = 64'h0100_0000_0000_0000;
  localparam matrix_t MATRIX_RESET = {ROW3_RESET, ROW2_RESET, ROW1_RESET, ROW0_RESET};

endpackage

`default_nettype wire

// ----- sv/m4vt_regs.sv -----
// APB-style register file holding the four 64-bit matrix rows.
// Depends on m4vt_pkg for the row types, register indexes and reset values.
`timescale 1ns / 1ps
`default_nettype none

module m4vt_regs (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [m4vt_pkg::ADDR_W-1:0] paddr,
  input  m4vt_pkg::row_t         pwdata,
  output m4vt_pkg::row_t         prdata,
  output logic                   pready,
  output m4vt_pkg::matrix_t      rows
);
  import m4vt_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = paddr[ADDR_W-1:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= MATRIX_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_ROW0: rows[0] <= pwdata;
        REG_ROW1: rows[1] <= pwdata;
        REG_ROW2: rows[2] <= pwdata;
        REG_ROW3: rows[3] <= pwdata;
        default:  rows <= rows;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ROW0: prdata = rows[0];
      REG_ROW1: prdata = rows[1];
      REG_ROW2: prdata = rows[2];
      REG_ROW3: prdata = rows[3];
      default:  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/m4vt_pipe.sv -----
// Four-stage dot-product pipeline: multiply, pair add, row sum with rounding,
// then shift and saturate. Depends on m4vt_pkg for the vector and matrix types.
`timescale 1ns / 1ps
`default_nettype none

module m4vt_pipe #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  m4vt_pkg::matrix_t coefs,
  input  logic              in_valid,
  output logic              in_ready,
  input  m4vt_pkg::vec_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output m4vt_pkg::vec_t    out_data,
  output logic              out_sat
);
  import m4vt_pkg::*;

  localparam int PW = COEF_WIDTH + VEC_W;
  localparam int SW = PW + 3;
  localparam logic signed [SW-1:0] RND  = (SW'(1) << FRAC_BITS) >> 1;
  localparam logic signed [SW-1:0] MAXV = SW'(32767);
  localparam logic signed [SW-1:0] MINV = SW'(-32768);

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  logic signed [COEF_WIDTH-1:0] coef_s [NUM_ROWS][NUM_COLS];
  logic signed [VEC_W-1:0]      vec_s  [NUM_COLS];
  logic signed [PW-1:0]         prod   [NUM_ROWS][NUM_COLS];
  logic signed [PW:0]           pair   [NUM_ROWS][2];
  logic signed [SW-1:0]         total  [NUM_ROWS];
  logic signed [SW-1:0]         shifted[NUM_ROWS];
  logic [VEC_W-1:0]             res    [NUM_ROWS];
  logic [NUM_ROWS-1:0]          lane_sat;

  // A stage loads when it is empty or its contents move on this cycle.
  assign en4      = !v4 || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        coef_s[r][c] = coefs[r][c*LANE_W +: COEF_WIDTH];
      end
    end
    for (int c = 0; c < NUM_COLS; c++) begin
      vec_s[c] = in_data[c*VEC_W +: VEC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // Stage 1: sixteen products.
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < NUM_COLS; c++) begin
          prod[r][c] <= coef_s[r][c] * vec_s[c];
        end
      end
    end
  end

  // Stage 2: pairwise sums.
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        pair[r][0] <= (PW+1)'(prod[r][0]) + (PW+1)'(prod[r][1]);
        pair[r][1] <= (PW+1)'(prod[r][2]) + (PW+1)'(prod[r][3]);
      end
    end
  end

  // Stage 3: row sum with half an output LSB added, so the later floor rounds.
  always_ff @(posedge clk) begin
    if (en3) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        total[r] <= SW'(pair[r][0]) + SW'(pair[r][1]) + RND;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      shifted[r] = total[r] >>> FRAC_BITS;
    end
  end

  // Stage 4: clip to signed 16 bits and collect the saturation flag.
  always_ff @(posedge clk) begin
    if (en4) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        if (shifted[r] > MAXV) begin
          res[r]      <= MAXV[VEC_W-1:0];
          lane_sat[r] <= 1'b1;
        end else if (shifted[r] < MINV) begin
          res[r]      <= MINV[VEC_W-1:0];
          lane_sat[r] <= 1'b1;
        end else begin
          res[r]      <= shifted[r][VEC_W-1:0];
          lane_sat[r] <= 1'b0;
        end
      end
    end
  end

  assign out_valid = v4;
  assign out_data  = {res[3], res[2], res[1], res[0]};
  assign out_sat   = |lane_sat;

  // Backpressure reaches the input only when every stage holds a request.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (v1 && v2 && v3 && v4))
    else $error("input blocked while a pipeline stage is empty");

  // At most one request enters per cycle, so occupancy grows by at most one.
  a_occupancy_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ($countones({v1, v2, v3, v4}) <= $past($countones({v1, v2, v3, v4})) + 1))
    else $error("pipeline occupancy grew by more than one request");

  // A saturated result must carry a clipped value in some lane.
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_sat) |->
      (res[0] == 16'h7fff || res[0] == 16'h8000 || res[1] == 16'h7fff ||
       res[1] == 16'h8000 || res[2] == 16'h7fff || res[2] == 16'h8000 ||
       res[3] == 16'h7fff || res[3] == 16'h8000))
    else $error("saturation flag without a clipped component");

endmodule

`default_nettype wire

// ----- sv/matrix4_vector_transform.sv -----
// Top level of the 4x4 matrix-vector transform: register file plus pipeline.
// Depends on m4vt_pkg, m4vt_regs and m4vt_pipe.
//
//  Channel   Direction  Handshake                  Payload
//  s_*       in         s_tvalid / s_tready        s_tdata: vec_x, vec_y, vec_z, vec_w
//  m_*       out        m_tvalid / m_tready        m_tdata: out_x..out_w, m_tuser: saturated
//  APB       in         psel, penable, pwrite      paddr, pwdata, prdata (64-bit rows)
//
// One request enters per cycle while s_tready is high. Each result is registered
// through the multiply, pair add, row sum and clip stages, in that order.
// Reset clears all stage valid bits and loads the identity matrix.
// A stall on m_tready holds a full stage only when every stage ahead of it is full;
// empty stages keep filling, so s_tready drops only when all four stages hold a request.
// Rows are sampled by stage 1, so the user must write them only while no request is
// in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module matrix4_vector_transform #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  // Input requests.
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  m4vt_pkg::vec_t              s_tdata,   // vec_x [15:0], vec_y, vec_z, vec_w [63:48]
  // Results.
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output m4vt_pkg::vec_t              m_tdata,   // out_x [15:0], out_y, out_z, out_w [63:48]
  output logic                        m_tuser,   // saturated [0]
  // Configuration.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [m4vt_pkg::ADDR_W-1:0] paddr,
  input  m4vt_pkg::row_t              pwdata,
  output m4vt_pkg::row_t              prdata,
  output logic                        pready
);
  import m4vt_pkg::*;

  matrix_t rows;

  // Matrix rows live in the register file; row r sits at byte address 8 * r.
  m4vt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rows    (rows)
  );

  // Each output component is one row dotted with the vector, rounded to
  // nearest with ties upward, then clipped to signed 16 bits.
  m4vt_pipe #(
    .COEF_WIDTH (COEF_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .coefs     (rows),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_sat   (m_tuser)
  );

endmodule

`default_nettype wire

// ----- bench/matrix4_vector_transform_tb.sv -----
// Self-checking bench for the 4x4 matrix-vector transform: reprograms the matrix,
// streams vectors under random back-pressure and checks every result.
// Depends on m4vt_pkg and matrix4_vector_transform.
`timescale 1ns / 1ps

module matrix4_vector_transform_tb;
  import m4vt_pkg::*;

  // Must match the parameters of the instance below.
  localparam int COEF_BITS  = 16;
  localparam int FRAC_PLACES = 8;
  localparam int CYCLE_LIMIT = 500000;
  // Four pipeline stages; allow a little extra when letting the block settle.
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic saturated;
    vec_t comps;
  } xform_result_t;

  // Scoreboard: keeps its own copy of the matrix, predicts the transform of
  // every accepted request and compares results in order.
  class transform_scoreboard;
    row_t          coef_rows[NUM_ROWS];
    xform_result_t pending[$];
    int            errors;

    function new();
      coef_rows[0] = ROW0_RESET;
      coef_rows[1] = ROW1_RESET;
      coef_rows[2] = ROW2_RESET;
      coef_rows[3] = ROW3_RESET;
      errors = 0;
    endfunction

    function void set_row(reg_idx_t idx, row_t value);
      coef_rows[idx] = value;
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] mismatch %s: got %h, want %h", $realtime, what, got, want);
      errors++;
    endtask

    // Dot each row with the vector, round half up, then clip to 16 bits.
    function void note_request(vec_t vec);
      xform_result_t res;
      longint acc;
      longint coef;
      longint comp;
      logic [LANE_W-1:0] lane;
      res = '0;
      for (int r = 0; r < NUM_ROWS; r++) begin
        acc = 0;
        for (int c = 0; c < NUM_COLS; c++) begin
          lane = coef_rows[r][LANE_W*c +: LANE_W];
          coef = longint'(lane) & ((longint'(1) << COEF_BITS) - 1);
          if (coef[COEF_BITS-1]) coef -= longint'(1) << COEF_BITS;
          comp = longint'($signed(vec[VEC_W*c +: VEC_W]));
          acc += coef * comp;
        end
        if (FRAC_PLACES > 0) acc += longint'(1) << (FRAC_PLACES - 1);
        acc = acc >>> FRAC_PLACES;
        if (acc > 32767) begin
          acc = 32767;
          res.saturated = 1'b1;
        end else if (acc < -32768) begin
          acc = -32768;
          res.saturated = 1'b1;
        end
        res.comps[VEC_W*r +: VEC_W] = acc[VEC_W-1:0];
      end
      pending.push_back(res);
    endfunction

    task check_result(vec_t comps, logic saturated);
      xform_result_t want;
      if (pending.size() == 0) begin
        report("result with nothing expected", comps, 64'(0));
      end else begin
        want = pending.pop_front();
        for (int r = 0; r < NUM_ROWS; r++) begin
          if (comps[VEC_W*r +: VEC_W] !== want.comps[VEC_W*r +: VEC_W])
            report($sformatf("component %0d", r), 64'(comps[VEC_W*r +: VEC_W]),
                   64'(want.comps[VEC_W*r +: VEC_W]));
        end
        if (saturated !== want.saturated)
          report("saturated flag", 64'(saturated), 64'(want.saturated));
      end
    endtask

    task check_leftover();
      if (pending.size() != 0)
        report("results never delivered", 64'(pending.size()), 64'(0));
    endtask
  endclass

  logic    clk;
  logic    rst;
  logic    s_tvalid;
  logic    s_tready;
  vec_t    s_tdata;   // vec_x [15:0], vec_y [31:16], vec_z [47:32], vec_w [63:48]
  logic    m_tvalid;
  logic    m_tready;
  vec_t    m_tdata;   // out_x [15:0], out_y [31:16], out_z [47:32], out_w [63:48]
  logic    m_tuser;   // saturated [0]
  logic    psel;
  logic    penable;
  logic    pwrite;
  logic [ADDR_W-1:0] paddr;
  row_t    pwdata;
  row_t    prdata;
  logic    pready;

  transform_scoreboard sb;

  // When set, both sides run without gaps.
  bit idle_off;
  // Number of cycles the receiver is to hold off; counted down by the receiver.
  int hold_request;
  longint unsigned cycle_count;

  matrix4_vector_transform #(
    .COEF_WIDTH(COEF_BITS),
    .FRAC_BITS (FRAC_PLACES)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is cut off here if the block stops moving.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("matrix4_vector_transform_tb: FAIL");
        $finish;
      end
    end
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (idle_off || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A vector component: half anything, the rest mostly moderate values with some extremes.
  function automatic logic [15:0] rand_component();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'h0000;
        3: return 16'hFFFF;
        default: return 16'h0001;
      endcase
    end
    if (r < 5) return 16'($urandom_range(0, 8191) - 4096);
    return 16'($urandom);
  endfunction

  function automatic vec_t rand_vector();
    vec_t v;
    for (int c = 0; c < NUM_COLS; c++) v[VEC_W*c +: VEC_W] = rand_component();
    return v;
  endfunction

  // A matrix row; the weight on small coefficients keeps many results in range
  // so that both saturated and clean results appear in every phase.
  function automatic row_t rand_row(int small_pct);
    row_t row;
    for (int c = 0; c < NUM_COLS; c++) begin
      if ($urandom_range(0, 99) < small_pct)
        row[LANE_W*c +: LANE_W] = 16'($urandom_range(0, 1023) - 512);
      else if ($urandom_range(0, 3) == 0)
        row[LANE_W*c +: LANE_W] = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
      else
        row[LANE_W*c +: LANE_W] = 16'($urandom);
    end
    return row;
  endfunction

  // Receiver: random stalls, plus a long hold-off when the main sequence asks.
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        m_tready = 1'b0;
      end else if (hold_request > 0) begin
        m_tready = 1'b0;
        hold_request--;
      end else if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        stall_left = pick_gap();
        m_tready = (stall_left == 0);
      end
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end
  end

  // Offer one request after a random gap and wait until it is taken. The valid
  // stays high between back-to-back requests; only the data changes.
  task automatic send_vector(vec_t vec);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      s_tdata  = 64'($urandom) << 32 | 64'($urandom);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = vec;
    do @(posedge clk); while (!s_tready);
    sb.note_request(vec);
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_vector(rand_vector());
  endtask

  // Stop offering and wait until every expected result is back, then let the
  // pipeline settle so the matrix can be changed safely.
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, row_t value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'(idx) << 3;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_row(idx, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Read a row back and compare it with the scoreboard's copy.
  task automatic apb_read(reg_idx_t idx);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = ADDR_W'(idx) << 3;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== sb.coef_rows[idx])
      sb.report($sformatf("read of row %0d", idx), prdata, sb.coef_rows[idx]);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic load_matrix(row_t r0, row_t r1, row_t r2, row_t r3);
    apb_write(REG_ROW0, r0);
    apb_write(REG_ROW1, r1);
    apb_write(REG_ROW2, r2);
    apb_write(REG_ROW3, r3);
    apb_read(REG_ROW0);
    apb_read(REG_ROW1);
    apb_read(REG_ROW2);
    apb_read(REG_ROW3);
  endtask

  task automatic load_random_matrix(int small_pct);
    load_matrix(rand_row(small_pct), rand_row(small_pct),
                rand_row(small_pct), rand_row(small_pct));
  endtask

  initial begin
    sb = new();
    idle_off     = 1'b0;
    hold_request = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // The reset matrix is the identity, so results equal the inputs. Reset rows 0
    // and 3 are read back before anything is written.
    apb_read(REG_ROW0);
    apb_read(REG_ROW3);
    send_vector({16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF});
    send_vector({16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001});
    send_vector('0);
    send_vector('1);
    drain();

    // Extreme coefficients: all-max and all-min rows saturate on large inputs,
    // a row of 0.5 in column 0 exposes ties, the last row mixes signs.
    load_matrix({4{16'h7FFF}}, {4{16'h8000}}, 64'h0000_0000_0000_0080,
                64'hFFFF_0001_8000_7FFF);
    send_vector({4{16'h7FFF}});
    send_vector({4{16'h8000}});
    send_vector({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
    // Exactly half an LSB either side of zero: ties round up.
    send_vector(64'h0000_0000_0000_0001);
    send_vector(64'h0000_0000_0000_FFFF);
    send_vector(64'h0000_0000_0000_0003);
    send_vector(64'h0000_0000_0000_FFFD);
    send_vector({16'h0000, 16'h0000, 16'h0001, 16'h0000});
    send_vector({16'h0001, 16'hFFFF, 16'h0000, 16'h0100});
    send_vector('0);
    send_vector('1);
    drain();

    // Random phases with varied matrices and idling patterns.
    load_random_matrix(70);
    send_random(120);
    drain();

    // No idling on either side for a whole phase.
    idle_off = 1'b1;
    load_random_matrix(50);
    send_random(110);
    drain();

    // Long hold-off: the receiver stops while the sender keeps offering, so
    // the pipeline fills and s_tready must drop until the receiver resumes.
    load_random_matrix(80);
    hold_request = 300;
    send_random(60);
    idle_off = 1'b0;
    // The sender pauses here until every expected result has come back.
    drain();
    send_random(70);
    drain();

    // Mostly full-range and extreme coefficients: saturation is common.
    load_random_matrix(10);
    send_random(120);
    drain();

    load_random_matrix(90);
    send_random(120);
    drain();

    // Back to the identity with explicit writes.
    load_matrix(ROW0_RESET, ROW1_RESET, ROW2_RESET, ROW3_RESET);
    send_random(135);
    drain();

    sb.check_leftover();
    if (sb.errors == 0) begin
      $display("matrix4_vector_transform_tb: PASS");
    end else begin
      $display("matrix4_vector_transform_tb: FAIL");
    end
    $finish;
  end

endmodule
